[hw/rtl/nd_snake_scan_index_generator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the N-dimensional snake scan index generator
// Shared helpers for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ND_SNAKE_SCAN_INDEX_GENERATOR_ASSERT_SVH
`define ND_SNAKE_SCAN_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSSIG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSSIG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/nssig_pkg.sv]
// ----------------------------------------------------------------------------
// nssig_pkg
// Types, constants and the step-pick function of the snake scan generator.
// ----------------------------------------------------------------------------
package nssig_pkg;

    localparam int MAX_DIMS = 4;
    localparam int MAX_SIZE = 256;
    localparam int DIM_W    = $clog2(MAX_DIMS);
    localparam int POS_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int ND_W     = 3;
    localparam int IDX_W    = 32;

    typedef enum logic [2:0] {
        REG_DIMS_USED = 3'd0,
        REG_SIZE_DIM0 = 3'd1,
        REG_SIZE_DIM1 = 3'd2,
        REG_SIZE_DIM2 = 3'd3,
        REG_SIZE_DIM3 = 3'd4
    } t_reg_idx;

    typedef logic [MAX_DIMS-1:0][POS_W-1:0]  t_coords;
    typedef logic [MAX_DIMS-1:0][SIZE_W-1:0] t_sizes;

    typedef struct packed {
        logic             found;
        logic [DIM_W-1:0] dim;
        logic             fwd;
    } t_pick;

    // Innermost dimension that can still move in its snake direction.
    // A dimension runs backward when the outer coordinates have odd parity.
    function automatic t_pick f_pick(input t_coords c, input t_sizes s);
        t_pick p;
        logic  par;
        p   = '0;
        par = 1'b0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (!par) begin
                if (({1'b0, c[k]} + SIZE_W'(1)) < s[k]) begin
                    p.found = 1'b1;
                    p.dim   = DIM_W'(k);
                    p.fwd   = 1'b1;
                end
            end else if (c[k] != '0) begin
                p.found = 1'b1;
                p.dim   = DIM_W'(k);
                p.fwd   = 1'b0;
            end
            par = par ^ c[k][0];
        end
        return p;
    endfunction

endpackage

[hw/rtl/nd_snake_scan_index_generator.sv]
// ----------------------------------------------------------------------------
// nd_snake_scan_index_generator
// Emits the boustrophedon visiting order of an up to 4-D grid, one point
// per request, with its row-major linear index and coordinates.
// ----------------------------------------------------------------------------
// A request's result is registered and shown in the cycle after its accept.
// Throughput: one request per cycle barring output stalls and settling, set
// by the single-pass step logic between walk state and result registers.
// Reset (synchronous, active low) restores one dimension of size one, ends
// any walk, and holds off requests while the stride multipliers settle. Every
// configuration write holds off requests; a defined index also ends the walk.
`include "nd_snake_scan_index_generator_assert.svh"

module nd_snake_scan_index_generator
    import nssig_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    // Request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_restart,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_linear_index,
    output logic [POS_W-1:0]  o_pos0,
    output logic [POS_W-1:0]  o_pos1,
    output logic [POS_W-1:0]  o_pos2,
    output logic [POS_W-1:0]  o_pos3,
    output logic              o_last_point,
    output logic              o_no_point
);

    // The two stride products each take one registered multiply, the outer one
    // from the inner, so the strides are valid only once both have settled.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // Configuration registers.
    logic [ND_W-1:0]  r_dims_used;
    t_sizes           r_size;

    // Walk state.
    t_coords          r_coord, n_coord;
    logic [IDX_W-1:0] r_index, n_index;
    logic             r_walk_active, n_walk_active;

    // Precomputed strides of the two outer dimensions.
    logic [2*SIZE_W-2:0] r_stride1;
    logic [3*SIZE_W-3:0] r_stride0;
    logic [1:0]          r_settle;

    // Result register.
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    t_coords          r_out_pos;
    logic             r_out_last;
    logic             r_out_none;

    logic             w_accept;
    logic [ND_W-1:0]  w_nd;
    t_sizes           w_es;
    t_pick            w_pick_cur;
    t_pick            w_pick_nxt;
    logic [IDX_W-1:0] w_delta;
    logic             w_none;
    logic             w_cfg_hit;
    logic             w_in_range;

    // ------------------------------------------------------------------
    // Configuration. A write to a defined register ends any walk.
    // ------------------------------------------------------------------
    always_comb begin
        unique case (t_reg_idx'(i_cfg_idx))
            REG_DIMS_USED, REG_SIZE_DIM0, REG_SIZE_DIM1,
            REG_SIZE_DIM2, REG_SIZE_DIM3: w_cfg_hit = i_cfg_we;
            default:                      w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims_used <= ND_W'(1);
            r_size      <= {MAX_DIMS{SIZE_W'(1)}};
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DIMS_USED: r_dims_used <= i_cfg_data[ND_W-1:0];
                REG_SIZE_DIM0: r_size[0]   <= i_cfg_data;
                REG_SIZE_DIM1: r_size[1]   <= i_cfg_data;
                REG_SIZE_DIM2: r_size[2]   <= i_cfg_data;
                REG_SIZE_DIM3: r_size[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimension count clamps to 1..MAX_DIMS. Each size clamps to
    // 1..MAX_SIZE, and a dimension outside the used range acts as size one,
    // which keeps it pinned at zero and out of the strides.
    always_comb begin
        if (r_dims_used == '0) begin
            w_nd = ND_W'(1);
        end else if (r_dims_used > ND_W'(MAX_DIMS)) begin
            w_nd = ND_W'(MAX_DIMS);
        end else begin
            w_nd = r_dims_used;
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (ND_W'(k) >= w_nd || r_size[k] == '0) begin
                w_es[k] = SIZE_W'(1);
            end else if (r_size[k] > SIZE_W'(MAX_SIZE)) begin
                w_es[k] = SIZE_W'(MAX_SIZE);
            end else begin
                w_es[k] = r_size[k];
            end
        end
    end

    // Stride of dimension d is the product of all inner effective sizes.
    always_ff @(posedge i_clk) begin
        r_stride1 <= (2*SIZE_W-1)'(w_es[2]) * (2*SIZE_W-1)'(w_es[3]);
        r_stride0 <= (3*SIZE_W-2)'(w_es[1]) * (3*SIZE_W-2)'(r_stride1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYCLES;
        end else if (i_cfg_we) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register frees up in the same cycle it drains.
    // ------------------------------------------------------------------
    assign o_in_ready = (r_settle == '0) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Step logic: pick the innermost movable dimension, move it by one and
    // adjust the linear index by that dimension's stride.
    // ------------------------------------------------------------------
    assign w_pick_cur = f_pick(r_coord, w_es);

    always_comb begin
        case (w_pick_cur.dim)
            2'd0:    w_delta = IDX_W'(r_stride0);
            2'd1:    w_delta = IDX_W'(r_stride1);
            2'd2:    w_delta = IDX_W'(w_es[3]);
            default: w_delta = IDX_W'(1);
        endcase
    end

    always_comb begin
        n_coord       = r_coord;
        n_index       = r_index;
        n_walk_active = r_walk_active;
        w_none        = 1'b0;
        if (i_restart) begin
            n_coord       = '0;
            n_index       = '0;
            n_walk_active = 1'b1;
        end else if (!r_walk_active) begin
            w_none = 1'b1;
        end else if (!w_pick_cur.found) begin
            // Advancing past the final point ends the walk.
            n_coord       = '0;
            n_index       = '0;
            n_walk_active = 1'b0;
            w_none        = 1'b1;
        end else if (w_pick_cur.fwd) begin
            n_coord[w_pick_cur.dim] = r_coord[w_pick_cur.dim] + POS_W'(1);
            n_index                 = r_index + w_delta;
        end else begin
            n_coord[w_pick_cur.dim] = r_coord[w_pick_cur.dim] - POS_W'(1);
            n_index                 = r_index - w_delta;
        end
    end

    // The point just reached is the last one when nothing can move from it.
    assign w_pick_nxt = f_pick(n_coord, w_es);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord       <= '0;
            r_index       <= '0;
            r_walk_active <= 1'b0;
        end else if (w_cfg_hit) begin
            r_coord       <= '0;
            r_index       <= '0;
            r_walk_active <= 1'b0;
        end else if (w_accept) begin
            r_coord       <= n_coord;
            r_index       <= n_index;
            r_walk_active <= n_walk_active;
        end
    end

    // ------------------------------------------------------------------
    // Result register. A result without a point carries zeros elsewhere.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_index <= w_none ? '0 : n_index;
            r_out_pos   <= w_none ? '0 : n_coord;
            r_out_last  <= !w_none && !w_pick_nxt.found;
            r_out_none  <= w_none;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_linear_index = r_out_index;
    assign o_pos0         = r_out_pos[0];
    assign o_pos1         = r_out_pos[1];
    assign o_pos2         = r_out_pos[2];
    assign o_pos3         = r_out_pos[3];
    assign o_last_point   = r_out_last;
    assign o_no_point     = r_out_none;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    always_comb begin
        w_in_range = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            if ({1'b0, r_coord[k]} >= w_es[k]) begin
                w_in_range = 1'b0;
            end
        end
    end

    `NSSIG_ASSERT_NOW(a_idle_state_zero, i_clk, i_rst_n,
        !r_walk_active, (r_index == '0) && (r_coord == '0),
        "walk state not cleared while no walk is active")

    `NSSIG_ASSERT_NOW(a_coord_in_grid, i_clk, i_rst_n,
        1'b1, w_in_range,
        "coordinate outside its effective dimension size")

    `NSSIG_ASSERT_NOW(a_no_point_zero, i_clk, i_rst_n,
        r_out_valid && r_out_none,
        (r_out_index == '0) && (r_out_pos == '0) && !r_out_last,
        "result without a point carries nonzero fields")

    `NSSIG_ASSERT_NEXT(a_cfg_holds_off, i_clk, i_rst_n,
        i_cfg_we, !o_in_ready,
        "request accepted before strides settled after a write")

    `NSSIG_ASSERT_NEXT(a_result_drains, i_clk, i_rst_n,
        r_out_valid && i_out_ready && !w_accept, !r_out_valid,
        "result register still valid after being taken")

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for nd_snake_scan_index_generator
// Drives restart/advance requests through the valid/ready channel while
// the result channel stalls at random. Every request is predicted by an
// independent snake walk model kept here, and each result is checked field
// by field. Register settings are changed between phases while the block
// is idle, including dimension counts and sizes that must saturate.
// ----------------------------------------------------------------------------
module testbench;
    import nssig_pkg::*;

    // Run control. The watchdog limit is far above the longest gap between
    // accepted requests or leaving results in a healthy run.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 8;
    localparam int RANDOM_REQS    = 800;
    localparam int IDLE_PERCENT   = 21;
    localparam int MAX_WALK_STEPS = 60;
    // Register codes past the last real register; writes there are dropped.
    localparam logic [2:0] FIRST_UNUSED_REG = 3'd5;
    localparam logic [2:0] LAST_UNUSED_REG  = 3'd7;

    // One expected or observed result.
    typedef struct packed {
        logic [IDX_W-1:0] linear_index;
        t_coords          pos;
        logic             last_point;
        logic             no_point;
    } t_point;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_restart;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [IDX_W-1:0]  o_linear_index;
    logic [POS_W-1:0]  o_pos0;
    logic [POS_W-1:0]  o_pos1;
    logic [POS_W-1:0]  o_pos2;
    logic [POS_W-1:0]  o_pos3;
    logic              o_last_point;
    logic              o_no_point;

    nd_snake_scan_index_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_linear_index (o_linear_index),
        .o_pos0         (o_pos0),
        .o_pos1         (o_pos1),
        .o_pos2         (o_pos2),
        .o_pos3         (o_pos3),
        .o_last_point   (o_last_point),
        .o_no_point     (o_no_point)
    );

    // ------------------------------------------------------------------------
    // Snake walk model: register copies and walk state.
    // ------------------------------------------------------------------------
    logic [ND_W-1:0]  cfg_dims;
    t_sizes           cfg_size;
    t_coords          walk_coords;
    logic [IDX_W-1:0] walk_index;
    logic             walk_on;

    // Stimulus and checking state.
    bit     pending_req[$];     // restart bit of each request still to be driven
    t_point expected_points[$]; // predicted results, oldest first
    bit     req_taken;          // set when the request on the bus was accepted
    bit     steady;             // suppresses idling on both sides
    bit     progress;
    int     idle_cycles;
    int     mismatches;
    int     reqs_accepted;
    int     results_checked;
    int     last_points_seen;
    int     no_points_seen;
    int     random_reqs;
    int     reg_settings;

    // Appends one request to the tail of the pending list.
    function automatic void queue_req(bit restart);
        pending_req.insert(pending_req.size(), restart);
    endfunction

    // Appends one predicted result to the tail of the expected list.
    function automatic void queue_expect(t_point pt);
        expected_points.insert(expected_points.size(), pt);
    endfunction

    // A dimension count of zero behaves as one; counts past the maximum
    // saturate. Sizes behave the same way between one and the maximum size.
    function automatic int unsigned dims_in_use();
        if (cfg_dims == '0) return 1;
        if (cfg_dims > MAX_DIMS) return MAX_DIMS;
        return 32'(cfg_dims);
    endfunction

    function automatic int unsigned extent(int k);
        if (cfg_size[k] == '0) return 1;
        if (cfg_size[k] > MAX_SIZE) return MAX_SIZE;
        return 32'(cfg_size[k]);
    endfunction

    function automatic longint unsigned grid_points();
        longint unsigned pts;
        pts = 1;
        for (int k = 0; k < dims_in_use(); k++) pts = pts * extent(k);
        return pts;
    endfunction

    function automatic void clear_walk();
        walk_coords = '0;
        walk_index  = '0;
        walk_on     = 1'b0;
    endfunction

    // Search from the innermost dimension outward for one that can still
    // step. A dimension runs backward when the outer coordinates sum odd.
    function automatic bit find_move(output int dim, output bit fwd);
        bit parity;
        dim = 0;
        fwd = 1'b1;
        for (int d = int'(dims_in_use()) - 1; d >= 0; d--) begin
            parity = 1'b0;
            for (int k = 0; k < d; k++) parity ^= walk_coords[k][0];
            if (!parity && (walk_coords[d] + 1 < extent(d))) begin
                dim = d;
                fwd = 1'b1;
                return 1'b1;
            end
            if (parity && walk_coords[d] != '0) begin
                dim = d;
                fwd = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // A register write always ends the walk, except at unused indexes.
    function automatic void apply_reg(logic [2:0] idx, logic [SIZE_W-1:0] value);
        case (idx)
            REG_DIMS_USED: cfg_dims    = value[ND_W-1:0];
            REG_SIZE_DIM0: cfg_size[0] = value;
            REG_SIZE_DIM1: cfg_size[1] = value;
            REG_SIZE_DIM2: cfg_size[2] = value;
            REG_SIZE_DIM3: cfg_size[3] = value;
            default:       return;
        endcase
        clear_walk();
    endfunction

    // Works out the result of one request and moves the walk along.
    function automatic t_point step_walk(bit restart);
        t_point pt;
        int     dim;
        bit     fwd;
        pt = '0;
        if (restart) begin
            clear_walk();
            walk_on = 1'b1;
        end else begin
            if (!walk_on) begin
                pt.no_point = 1'b1;
                return pt;
            end
            if (!find_move(dim, fwd)) begin
                // Stepping past the final point ends the walk.
                clear_walk();
                pt.no_point = 1'b1;
                return pt;
            end
            if (fwd) walk_coords[dim] = walk_coords[dim] + 1'b1;
            else walk_coords[dim] = walk_coords[dim] - 1'b1;
        end
        walk_index = '0;
        for (int k = 0; k < dims_in_use(); k++) begin
            walk_index = walk_index * extent(k) + walk_coords[k];
        end
        pt.linear_index = walk_index;
        pt.pos          = walk_coords;
        pt.last_point   = !find_move(dim, fwd);
        return pt;
    endfunction

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver. Everything changes on the falling edge. A request stays on the
    // bus, unchanged, until the sampler reports it accepted; only then may
    // the next one go out, or valid drop while the driver idles.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_in_valid || req_taken) begin
            if (pending_req.size() != 0
                    && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                i_in_valid <= 1'b1;
                i_restart  <= pending_req.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Sampler and monitor on the rising edge. The result side is handled
    // before the request side; a result can never belong to the request
    // accepted at the same edge because the block registers its output.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (o_out_valid && i_out_ready) begin
                t_point got;
                t_point want;
                got.linear_index = o_linear_index;
                got.pos          = {o_pos3, o_pos2, o_pos1, o_pos0};
                got.last_point   = o_last_point;
                got.no_point     = o_no_point;
                progress         = 1'b1;
                results_checked++;
                last_points_seen += got.last_point;
                no_points_seen   += got.no_point;
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %0d pos %0d/%0d/%0d/%0d",
                                 got.linear_index, got.pos[0], got.pos[1],
                                 got.pos[2], got.pos[3]);
                end else begin
                    want = expected_points.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: index %0d/%0d ",
                                      "pos %0d,%0d,%0d,%0d/%0d,%0d,%0d,%0d ",
                                      "last %0b/%0b none %0b/%0b (expected/actual)"},
                                     results_checked, want.linear_index,
                                     got.linear_index, want.pos[0], want.pos[1],
                                     want.pos[2], want.pos[3], got.pos[0], got.pos[1],
                                     got.pos[2], got.pos[3], want.last_point,
                                     got.last_point, want.no_point, got.no_point);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                queue_expect(step_walk(i_restart));
                req_taken = 1'b1;
                progress  = 1'b1;
                reqs_accepted++;
            end
            // The watchdog only looks for a channel that stopped moving.
            if (progress || i_cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result for %0d cycles", idle_cycles);
                $display("** nd_snake_scan_index_generator: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Writes one register; the model follows at the same edge as the block.
    task automatic write_reg(input logic [2:0] idx, input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        apply_reg(idx, value);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_settings++;
    endtask

    // Waits until every queued request went out and every result came back.
    // Results are one per request, so nothing is left in flight after that.
    task automatic drain();
        while (pending_req.size() != 0 || i_in_valid || expected_points.size() != 0)
            @(posedge i_clk);
    endtask

    // A restart, every step of the walk, and one step past its end.
    task automatic queue_full_walk();
        longint unsigned pts;
        pts = grid_points();
        queue_req(1'b1);
        repeat (pts) queue_req(1'b0);
        random_reqs += int'(pts) + 1;
    endtask

    // Mostly well-formed walks, some cut short, with random restart and
    // advance requests mixed in as noise.
    task automatic queue_walks(int budget);
        longint unsigned pts;
        int              steps;
        int              queued;
        pts    = grid_points();
        queued = 0;
        while (queued < budget) begin
            if ($urandom_range(99) < 85) begin
                if (pts > MAX_WALK_STEPS) steps = $urandom_range(1, MAX_WALK_STEPS);
                else steps = int'(pts) - 1 + $urandom_range(0, 2);
                if ($urandom_range(3) == 0) steps = $urandom_range(0, steps);
                queue_req(1'b1);
                repeat (steps) queue_req(1'b0);
                queued += steps + 1;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    queue_req(1'($urandom_range(1)));
                    queued++;
                end
            end
        end
        random_reqs += queued;
    endtask

    // Mostly tiny sizes so walks finish; now and then any 9-bit value.
    function automatic logic [SIZE_W-1:0] pick_size();
        if ($urandom_range(99) < 80) return SIZE_W'($urandom_range(0, 5));
        return SIZE_W'($urandom_range(0, 2 ** SIZE_W - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int directed_reqs;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_out_ready = 1'b0;
        req_taken   = 1'b0;
        steady      = 1'b0;
        cfg_dims    = ND_W'(1);
        for (int k = 0; k < MAX_DIMS; k++) cfg_size[k] = SIZE_W'(1);
        clear_walk();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the single-point grid left by reset. An advance with no
        // walk, a restart that is also the last point, a step past the end,
        // and an advance once the walk has ended.
        queue_req(1'b0);
        queue_req(1'b1);
        queue_req(1'b0);
        queue_req(1'b0);
        drain();

        // A 3 x 4 grid walked to the end, which turns the inner dimension.
        write_reg(REG_DIMS_USED, 2);
        write_reg(REG_SIZE_DIM0, 3);
        write_reg(REG_SIZE_DIM1, 4);
        end_writes();
        queue_full_walk();
        drain();

        // Part of a walk, then a write to an unused register index, which
        // must not disturb the walk.
        queue_req(1'b1);
        queue_req(1'b0);
        queue_req(1'b0);
        drain();
        write_reg(FIRST_UNUSED_REG, '1);
        end_writes();
        queue_req(1'b0);
        drain();

        // A real register write in the middle of a walk aborts it.
        write_reg(REG_SIZE_DIM2, 0);
        end_writes();
        queue_req(1'b0);
        drain();
        directed_reqs = reqs_accepted;
        random_reqs   = 0;

        // Extremes. A zero dimension count and an oversize length: one
        // dimension of the largest size, walked end to end with no idling.
        write_reg(REG_DIMS_USED, 0);
        write_reg(REG_SIZE_DIM0, '1);
        end_writes();
        steady = 1'b1;
        queue_full_walk();
        drain();
        steady = 1'b0;

        // An oversize dimension count gives all four dimensions; a zero
        // size counts as one.
        write_reg(REG_DIMS_USED, '1);
        write_reg(REG_SIZE_DIM0, 0);
        write_reg(REG_SIZE_DIM1, 3);
        write_reg(REG_SIZE_DIM2, 2);
        write_reg(REG_SIZE_DIM3, 2);
        end_writes();
        queue_full_walk();
        drain();

        // The largest grid, only partly walked.
        write_reg(REG_DIMS_USED, 4);
        write_reg(REG_SIZE_DIM0, SIZE_W'(MAX_SIZE));
        write_reg(REG_SIZE_DIM1, SIZE_W'(MAX_SIZE));
        write_reg(REG_SIZE_DIM2, SIZE_W'(MAX_SIZE));
        write_reg(REG_SIZE_DIM3, SIZE_W'(MAX_SIZE));
        end_writes();
        queue_walks(40);
        drain();

        // Random settings, each followed by a batch of walks. A phase may
        // stop mid-walk, so the next register write also aborts walks.
        while (random_reqs < RANDOM_REQS) begin
            write_reg(REG_DIMS_USED, SIZE_W'($urandom_range(0, 2 ** ND_W - 1)));
            write_reg(REG_SIZE_DIM0, pick_size());
            write_reg(REG_SIZE_DIM1, pick_size());
            write_reg(REG_SIZE_DIM2, pick_size());
            write_reg(REG_SIZE_DIM3, pick_size());
            if ($urandom_range(3) == 0)
                write_reg(3'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                          SIZE_W'($urandom));
            end_writes();
            queue_walks($urandom_range(20, 70));
            drain();
        end

        // Let any stray result show up before judging the run.
        repeat (END_WAIT) @(posedge i_clk);
        $display("Checked %0d results for %0d requests (%0d directed) across %0d settings.",
                 results_checked, reqs_accepted, directed_reqs, reg_settings);
        $display("Walk ends seen: %0d last points, %0d empty results; %0d mismatches.",
                 last_points_seen, no_points_seen, mismatches);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("** nd_snake_scan_index_generator: PASSED **");
        end else begin
            $display("** nd_snake_scan_index_generator: FAILED **");
        end
        $finish;
    end

endmodule
